>>> hw/rtl/blamka_block_compress_assert.svh
// Assertion macros for the BlaMka block compression.
`ifndef BLAMKA_BLOCK_COMPRESS_ASSERT_SVH
`define BLAMKA_BLOCK_COMPRESS_ASSERT_SVH
// Implication checked every cycle outside reset.
`define BBC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// Implication checked in the next cycle.
`define BBC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`endif

>>> hw/rtl/bbc_pkg.sv
// Package: types, constants and the BlaMka helper functions.
`default_nettype none
package bbc_pkg;
  localparam int BlockWords = 128;
  localparam int AddrW = 7;
  localparam int WordW = 64;
  typedef logic [WordW-1:0] word_t;
  typedef logic [AddrW-1:0] addr_t;

  // Round-internal register index of the four words of G number gi (0..7).
  function automatic logic [3:0] g_idx(input logic [2:0] gi, input logic [1:0] r);
    logic [3:0] res;
    logic [1:0] c;
    begin
      c = gi[1:0];
      if (!gi[2]) begin
        res = {r, c};
      end else begin
        res = {r, 2'(c + r)};
      end
      return res;
    end
  endfunction

  // Block address of slot k (0..15) of pass p (0..15).
  function automatic addr_t slot_addr(input logic [3:0] p, input logic [3:0] k);
    addr_t res;
    begin
      if (!p[3]) begin
        res = {p[2:0], k};
      end else begin
        res = {k[3:1], p[2:0], k[0]};
      end
      return res;
    end
  endfunction

  function automatic word_t rotr(input word_t x, input logic [1:0] sel);
    word_t res;
    begin
      case (sel)
        2'd0: res = {x[31:0], x[63:32]};
        2'd1: res = {x[23:0], x[63:24]};
        2'd2: res = {x[15:0], x[63:16]};
        default: res = {x[62:0], x[63]};
      endcase
      return res;
    end
  endfunction
endpackage
`default_nettype wire

>>> hw/rtl/bbc_if.sv
// Valid/ready channel interfaces for input and output pairs.
`default_nettype none
interface bbc_in_if;
  logic valid;
  logic ready;
  logic [63:0] word_even;
  logic [63:0] word_odd;
  modport source (output valid, output word_even, output word_odd, input ready);
  modport sink (input valid, input word_even, input word_odd, output ready);
endinterface

interface bbc_out_if;
  logic valid;
  logic ready;
  logic [63:0] out_even;
  logic [63:0] out_odd;
  logic block_done;
  modport source (output valid, output out_even, output out_odd, output block_done,
                  input ready);
  modport sink (input valid, input out_even, input out_odd, input block_done,
                output ready);
endinterface
`default_nettype wire

>>> hw/rtl/bbc_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
`default_nettype none
module bbc_ram #(
  parameter int Depth = 128,
  parameter int Width = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] waddr,
  input  wire logic [Width-1:0]         wdata,
  input  wire logic [$clog2(Depth)-1:0] raddr,
  output      logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

>>> hw/rtl/bbc_gunit.sv
// BlaMka G unit: four steps, each a registered product then an add and xor-rotate.
`default_nettype none
module bbc_gunit (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  wire bbc_pkg::word_t a_in,
  input  wire bbc_pkg::word_t b_in,
  input  wire bbc_pkg::word_t c_in,
  input  wire bbc_pkg::word_t d_in,
  output      logic          done,
  output      bbc_pkg::word_t a,
  output      bbc_pkg::word_t b,
  output      bbc_pkg::word_t c,
  output      bbc_pkg::word_t d
);
  import bbc_pkg::*;
  // Each half step: phase 0 registers the product, phase 1 adds and mixes.
  logic [1:0] step;
  logic       busy;
  logic       ph;
  logic [63:0] prod;
  word_t x, y, sum;
  logic [1:0] rsel;

  always_comb begin
    // step[0]: 0 -> a += b ; d = rot(d^a) ; 1 -> c += d ; b = rot(b^c)
    // rotation per step: 32, 24, 16, 63
    x = step[0] ? c : a;
    y = step[0] ? d : b;
    sum = x + y + {prod[62:0], 1'b0};
    rsel = step;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
        ph <= 1'b0;
        a <= a_in; b <= b_in; c <= c_in; d <= d_in;
      end else if (busy) begin
        if (!ph) begin
          prod <= 64'(x[31:0]) * 64'(y[31:0]);
          ph <= 1'b1;
        end else begin
          ph <= 1'b0;
          if (!step[0]) begin
            a <= sum;
            d <= rotr(d ^ sum, rsel);
          end else begin
            c <= sum;
            b <= rotr(b ^ sum, rsel);
          end
          step <= step + 2'd1;
          if (step == 2'd3) begin
            busy <= 1'b0;
            done <= 1'b1;
          end
        end
      end
    end
  end

  `include "blamka_block_compress_assert.svh"
  `BBC_ASSERT_NEXT(a_start_busy, start, busy, "G unit not busy after start")
  `BBC_ASSERT_NEXT(a_done_pulse, done, !done, "G done longer than one cycle")
  `BBC_ASSERT_IMP(a_no_restart, busy, !start, "G unit restarted while busy")
endmodule
`default_nettype wire

>>> hw/rtl/blamka_block_compress.sv
// Top level: BlaMka block compression with input and work block memories.
//
//  Channel | Dir | Payload                          | Transactions per block
//  inp     | in  | word_even, word_odd              | 64
//  outp    | out | out_even, out_odd, block_done    | 64
//
// Fill: each pair goes to both memories, even word in the accept cycle and
// odd word the cycle after; ready is low while the odd word is written.
// A new pair is not taken while the odd word of the last is written (one memory write port per word).
// Permute: 16 passes; each pass loads 16 words, runs 8 G calls on the one
// shared G unit, and stores 16 words.
// Output: each pair is the xor of both memories, held while ready is low.
// Output waits for ready, no skid needed.
// Reset clears only control state; memory contents need no clearing.
`default_nettype none
module blamka_block_compress (
  input wire logic clk,
  input wire logic rst,
  bbc_in_if.sink   inp,
  bbc_out_if.source outp
);
  import bbc_pkg::*;

  typedef enum logic [6:0] {
    S_FILL  = 7'b0000001,
    S_FILL2 = 7'b0000010,
    S_LOAD  = 7'b0000100,
    S_GRUN  = 7'b0001000,
    S_STORE = 7'b0010000,
    S_OUT   = 7'b0100000,
    S_OUTW  = 7'b1000000
  } state_t;

  state_t state;
  addr_t  fill;        // next word address in the block
  word_t  odd_hold;    // odd word waiting for its write cycle
  logic [3:0] pass;
  logic [4:0] k;       // slot counter for load/store/out
  logic [2:0] gi;
  logic       gwait;
  logic       out_ph;  // output: 0 fetch even, 1 fetch odd
  logic       last;    // upper bit of the output pair index {last, k}
  word_t v [16];
  word_t even_x;

  // Memories.
  logic  in_we, wk_we;
  addr_t in_wa, wk_wa, in_ra, wk_ra;
  word_t in_wd, wk_wd, in_rd, wk_rd;

  bbc_ram #(.Depth(BlockWords), .Width(WordW)) u_in_ram (
    .clk, .we(in_we), .waddr(in_wa), .wdata(in_wd), .raddr(in_ra), .rdata(in_rd));
  bbc_ram #(.Depth(BlockWords), .Width(WordW)) u_wk_ram (
    .clk, .we(wk_we), .waddr(wk_wa), .wdata(wk_wd), .raddr(wk_ra), .rdata(wk_rd));

  // G unit.
  logic gstart, gdone;
  word_t ga, gb, gc, gd;
  logic [3:0] ia, ib, ic, id;
  assign ia = g_idx(gi, 2'd0);
  assign ib = g_idx(gi, 2'd1);
  assign ic = g_idx(gi, 2'd2);
  assign id = g_idx(gi, 2'd3);

  bbc_gunit u_g (
    .clk, .rst, .start(gstart),
    .a_in(v[ia]), .b_in(v[ib]), .c_in(v[ic]), .d_in(v[id]),
    .done(gdone), .a(ga), .b(gb), .c(gc), .d(gd));

  assign inp.ready = (state == S_FILL);
  assign gstart = (state == S_GRUN) && !gwait;

  always_comb begin
    in_we = 1'b0; wk_we = 1'b0;
    in_wa = fill; wk_wa = fill;
    in_wd = inp.word_even; wk_wd = inp.word_even;
    in_ra = {last, k, out_ph};
    wk_ra = slot_addr(pass, k[3:0]);
    case (state)
      S_FILL: begin
        in_we = inp.valid; wk_we = inp.valid;
      end
      S_FILL2: begin
        in_we = 1'b1; wk_we = 1'b1;
        in_wd = odd_hold; wk_wd = odd_hold;
      end
      S_STORE: begin
        wk_we = 1'b1;
        wk_wa = slot_addr(pass, k[3:0]);
        wk_wd = v[k[3:0]];
      end
      S_OUT, S_OUTW: begin
        wk_ra = {last, k, out_ph};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_FILL;
      fill <= '0;
      outp.valid <= 1'b0;
      k <= '0;
      gwait <= 1'b0;
      last <= 1'b0;
    end else begin
      case (state)
        S_FILL: if (inp.valid) begin
          odd_hold <= inp.word_odd;
          fill <= fill + addr_t'(1);
          state <= S_FILL2;
        end
        S_FILL2: begin
          fill <= fill + addr_t'(1);
          if (fill == addr_t'(BlockWords - 1)) begin
            state <= S_LOAD; pass <= '0; k <= '0;
          end else begin
            state <= S_FILL;
          end
        end
        S_LOAD: begin
          // read address k issued this cycle; data from k-1 arrives
          if (k != 5'd0) v[4'(k - 5'd1)] <= wk_rd;
          if (k == 5'd16) begin
            state <= S_GRUN; gi <= '0; gwait <= 1'b0; k <= '0;
          end else begin
            k <= k + 5'd1;
          end
        end
        S_GRUN: begin
          if (gstart) gwait <= 1'b1;
          if (gdone) begin
            v[ia] <= ga; v[ib] <= gb; v[ic] <= gc; v[id] <= gd;
            gwait <= 1'b0;
            gi <= gi + 3'd1;
            if (gi == 3'd7) begin
              state <= S_STORE; k <= '0;
            end
          end
        end
        S_STORE: begin
          if (k == 5'd15) begin
            k <= '0;
            pass <= pass + 4'd1;
            if (pass == 4'd15) begin
              state <= S_OUT; out_ph <= 1'b0;
            end else begin
              state <= S_LOAD;
            end
          end else begin
            k <= k + 5'd1;
          end
        end
        S_OUT: begin
          // addresses for the even word issued last cycle or now
          if (!out_ph) begin
            out_ph <= 1'b1;
          end else begin
            // even data now present
            even_x <= in_rd ^ wk_rd;
            out_ph <= 1'b0;
            state <= S_OUTW;
          end
        end
        S_OUTW: begin
          if (!outp.valid) begin
            // odd data present (issued in S_OUT with out_ph high)
            outp.out_even <= even_x;
            outp.out_odd <= in_rd ^ wk_rd;
            outp.block_done <= (k == 5'd31) ? last : 1'b0;
            outp.valid <= 1'b1;
          end else if (outp.ready) begin
            outp.valid <= 1'b0;
            if (k == 5'd31 && last) begin
              state <= S_FILL; k <= '0;
            end else begin
              {last, k} <= {last, k} + 6'd1;
              state <= S_OUT;
            end
          end
        end
        default: state <= S_FILL;
      endcase
      if (state == S_FILL2 && fill == addr_t'(BlockWords - 1)) last <= 1'b0;
    end
  end

  `include "blamka_block_compress_assert.svh"
  `BBC_ASSERT_IMP(a_ready_fill, inp.ready, state == S_FILL, "ready outside fill")
  `BBC_ASSERT_IMP(a_gstart_run, gstart, state == S_GRUN, "G start outside run")
  `BBC_ASSERT_IMP(a_valid_out, outp.valid, state == S_OUTW, "valid outside output")
endmodule
`default_nettype wire
